// ===== rtl/acd_pkg.sv =====
package acd_pkg;

  localparam int unsigned ColourW = 6;
  localparam int unsigned AttrW   = 8;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [ColourW-1:0] ColourWhite = 6'h2A;
  localparam logic [ColourW-1:0] ColourBlack = 6'h00;

  localparam int unsigned BitBright = 6;
  localparam int unsigned BitFlash  = 7;

  // register indexes (paddr[3:2])
  localparam logic [1:0] RegDoubleByte   = 2'd0;
  localparam logic [1:0] RegExtraColours = 2'd1;
  localparam logic [1:0] RegHalfCell     = 2'd2;

  typedef struct packed {
    logic [AttrW-1:0] attr_first;
    logic [AttrW-1:0] attr_second;
    logic             flash_phase;
  } attr_in_t;

  typedef struct packed {
    logic [ColourW-1:0] ink_left;
    logic [ColourW-1:0] ink_right;
    logic [ColourW-1:0] paper_left;
    logic [ColourW-1:0] paper_right;
  } colour_out_t;

  // pre-decoded colours of both bytes, mode independent
  typedef struct packed {
    logic [ColourW-1:0] a_lo;
    logic [ColourW-1:0] a_hi;
    logic [ColourW-1:0] b_lo;
    logic [ColourW-1:0] b_hi;
    logic [ColourW-1:0] a_dir;
    logic [ColourW-1:0] b_dir;
    logic [ColourW-1:0] a_wb;
    logic               swap_ink;
    logic               swap_paper;
  } decode_t;

  // bits 2..0 (g,r,b) to colour bits 5,3,1
  function automatic logic [ColourW-1:0] low_colour(input logic [AttrW-1:0] a);
    low_colour = {a[2], 1'b0, a[1], 1'b0, a[0], 1'b0};
  endfunction

  // bits 5..3 (g,r,b) to colour bits 5,3,1
  function automatic logic [ColourW-1:0] high_colour(input logic [AttrW-1:0] a);
    high_colour = {a[5], 1'b0, a[4], 1'b0, a[3], 1'b0};
  endfunction

  function automatic logic [ColourW-1:0] brighten(input logic [ColourW-1:0] c,
                                                  input logic [AttrW-1:0] a);
    brighten = a[BitBright] ? (c | (c >> 1)) : c;
  endfunction

endpackage

// ===== rtl/attribute_colour_decode.sv =====
// An accepted input beat passes through the input, pre-decode and output registers in that
// order; its result shows on out_* once the output register has captured it.
// Throughput: one beat per cycle while out_stall is low; three register stages (input,
// pre-decode, mode select / flash swap), each stage refills while the next one drains.
// Reset (rst_n low, synchronous): all stage valids and the three mode
// registers clear to 0; the pipeline is empty and accepts on the next cycle.
module attribute_colour_decode (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  acd_pkg::attr_in_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output acd_pkg::colour_out_t           out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [acd_pkg::CfgAddrW-1:0]   paddr,
  input  logic [acd_pkg::CfgDataW-1:0]   pwdata,
  output logic [acd_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);
  import acd_pkg::*;

  logic double_byte_r, extra_colours_r, half_cell_r;

  logic        s1_valid_r, s2_valid_r, out_valid_r;
  attr_in_t    s1_r;
  decode_t     s2_r, s2_nxt;
  colour_out_t out_r, out_nxt;
  logic        s1_ready, s2_ready, out_ready;
  logic        cfg_wr;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      double_byte_r   <= 1'b0;
      extra_colours_r <= 1'b0;
      half_cell_r     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegDoubleByte:   double_byte_r   <= pwdata[0];
        RegExtraColours: extra_colours_r <= pwdata[0];
        RegHalfCell:     half_cell_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      RegDoubleByte:   prdata[0] = double_byte_r;
      RegExtraColours: prdata[0] = extra_colours_r;
      RegHalfCell:     prdata[0] = half_cell_r;
      default:         prdata[0] = 1'b0;
    endcase
  end

  // ---------------- handshake ----------------
  assign out_ready = !out_valid_r || !out_stall;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_stall  = !s1_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_r  <= in_valid;
      if (s2_ready)  s2_valid_r  <= s1_valid_r;
      if (out_ready) out_valid_r <= s2_valid_r;
    end
  end

  // ---------------- stage 1: capture ----------------
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) s1_r <= in_data;
  end

  // ---------------- stage 2: per-byte decode ----------------
  always_comb begin
    s2_nxt.a_lo       = brighten(low_colour(s1_r.attr_first), s1_r.attr_first);
    s2_nxt.a_hi       = brighten(high_colour(s1_r.attr_first), s1_r.attr_first);
    s2_nxt.b_lo       = brighten(low_colour(s1_r.attr_second), s1_r.attr_second);
    s2_nxt.b_hi       = brighten(high_colour(s1_r.attr_second), s1_r.attr_second);
    s2_nxt.a_dir      = s1_r.attr_first[ColourW-1:0];
    s2_nxt.b_dir      = s1_r.attr_second[ColourW-1:0];
    s2_nxt.a_wb       = s1_r.attr_first[BitBright] ? ColourWhite : ColourBlack;
    s2_nxt.swap_ink   = s1_r.flash_phase & s1_r.attr_first[BitFlash];
    s2_nxt.swap_paper = s1_r.flash_phase & s1_r.attr_second[BitFlash];
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) s2_r <= s2_nxt;
  end

  // ---------------- stage 3: mode select and flash swap ----------------
  always_comb begin
    logic [ColourW-1:0] il, ir, pl, pr;
    unique case ({half_cell_r, extra_colours_r, double_byte_r})
      3'b000: begin
        il = s2_r.a_lo;  pl = s2_r.a_hi;  ir = il;  pr = pl;
      end
      3'b001: begin
        il = s2_r.a_lo;  pl = s2_r.b_lo;  ir = il;  pr = pl;
      end
      3'b010: begin
        il = s2_r.a_dir; pl = s2_r.a_wb;  ir = il;  pr = pl;
      end
      3'b011: begin
        il = s2_r.a_dir; pl = s2_r.b_dir; ir = il;  pr = pl;
      end
      3'b100: begin
        ir = s2_r.a_lo;  il = s2_r.a_hi;  pl = ColourBlack; pr = ColourBlack;
      end
      3'b101: begin
        ir = s2_r.a_lo;  il = s2_r.a_hi;  pr = s2_r.b_lo;  pl = s2_r.b_hi;
      end
      3'b110: begin
        ir = s2_r.a_dir; il = s2_r.a_wb;  pl = ColourBlack; pr = ColourBlack;
      end
      default: begin
        ir = s2_r.a_dir; il = s2_r.b_dir; pl = ColourBlack; pr = ColourBlack;
      end
    endcase
    // paper takes the pre-swap ink
    out_nxt.ink_left    = s2_r.swap_ink   ? pl : il;
    out_nxt.ink_right   = s2_r.swap_ink   ? pr : ir;
    out_nxt.paper_left  = s2_r.swap_paper ? il : pl;
    out_nxt.paper_right = s2_r.swap_paper ? ir : pr;
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid_r) out_r <= out_nxt;
  end

  // ---------------- assertions ----------------
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !s1_valid_r && !s2_valid_r)
    else $error("pipeline not empty after reset");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with empty first stage");

  a_s2_advances: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("beat lost between decode and output stage");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r && $stable(s1_r))
    else $error("first stage changed while blocked");

endmodule
